// File: sv/rrq_pkg.sv
// Package: scheduler types, constants and operation/status codes.
package rrq_pkg;
  localparam int MaxThreads = 16;
  localparam int WaitQueues = 8;
  localparam int StackBits  = 16;
  localparam int SlotBits   = 4;
  localparam int QueueBits  = 3;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_ADVANCE = 3'd1;
  localparam logic [2:0] OP_SAVE    = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_BLOCK   = 3'd4;
  localparam logic [2:0] OP_RESUME  = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NULL   = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_ORPHAN = 3'd4;
  localparam logic [2:0] ST_QEMPTY = 3'd5;

  typedef struct packed {
    logic [2:0]           op;
    logic [StackBits-1:0] stack_value;
    logic [2:0]           queue_index;
  } req_t;

  typedef struct packed {
    logic [StackBits-1:0] stack_out;
    logic [SlotBits-1:0]  thread_slot;
    logic [2:0]           status;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request
    logic link;    // table read phase
    logic commit;  // apply updates, emit result
  } cmd_t;
endpackage

// File: sv/round_robin_ready_ring_with_wait_queues.sv
// Top level: round-robin thread scheduler with FIFO wait queues.
// Each request (start while busy is low) goes through capture, a table read
// phase, then commit; its result appears on rsp_o for exactly one cycle with
// done_o high, in the cycle after commit. The three-step sequencer does not
// take a new request until the previous result has been shown. There is no
// backpressure: the receiver must take every result in the cycle it is shown.
// Tables hold garbage until written, so stack_out from a never-pushed slot is
// undefined.
module round_robin_ready_ring_with_wait_queues (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rrq_pkg::req_t req_i,
  output logic          done_o,
  output rrq_pkg::rsp_t rsp_o
);
  import rrq_pkg::*;
  cmd_t cmd;
  logic ctrl_busy;

  // start is masked from the controller while the result is shown; it ignores start in its other busy states
  rrq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start & ~done_o), .busy_o(ctrl_busy), .cmd_o(cmd)
  );

  rrq_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .req_i, .strobe_o(done_o), .rsp_o
  );

  // also busy while the result is shown, so requests never overlap
  assign busy = ctrl_busy | done_o;
endmodule

// File: sv/rrq_ctrl.sv
// Controller: three-step sequencer per request.
module rrq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output rrq_pkg::cmd_t cmd_o
);
  import rrq_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LINK = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_LINK;
      S_LINK:   state_d = S_COMMIT;
      S_COMMIT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign cmd_o.load  = state_q == S_IDLE && start_i;
  assign cmd_o.link  = state_q == S_LINK;
  assign cmd_o.commit = state_q == S_COMMIT;
endmodule

// File: sv/rrq_dp.sv
// Datapath: slot tables, ring links, wait queues and result register.
module rrq_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rrq_pkg::cmd_t cmd_i,
  input  rrq_pkg::req_t req_i,
  output logic          strobe_o,
  output rrq_pkg::rsp_t rsp_o
);
  import rrq_pkg::*;

  logic [StackBits-1:0] stk_q [MaxThreads];
  logic [SlotBits-1:0]  fwd_q [MaxThreads];
  logic [SlotBits-1:0]  bwd_q [MaxThreads];
  logic [SlotBits-1:0]  wlk_q [MaxThreads];
  logic [SlotBits-1:0]  qfirst_q [WaitQueues];
  logic [SlotBits-1:0]  qlast_q [WaitQueues];
  logic [WaitQueues-1:0] qocc_q;
  logic [SlotBits:0]    used_q;
  logic [SlotBits-1:0]  run_q, up_q, head_q, tail_q;
  logic                 runv_q;

  req_t                 r_q;
  logic [SlotBits-1:0]  cfwd_q, cbwd_q, tfwd_q, t_q, qf_q, ql_q, tlk_q, ts_q;
  logic [StackBits-1:0] cstk_q, ustk_q;
  logic                 strobe_q;
  rsp_t                 rsp_q;

  logic [QueueBits-1:0] qi;
  assign qi = r_q.queue_index;
  logic [SlotBits-1:0] us;
  assign us = used_q[SlotBits-1:0];

  // step 1: capture the request; step 2: read entries indexed by the captured request and ring pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= req_i;
    if (cmd_i.link) begin
      cfwd_q <= fwd_q[run_q];
      cbwd_q <= bwd_q[run_q];
      tfwd_q <= fwd_q[tail_q];
      cstk_q <= stk_q[run_q];
      ustk_q <= stk_q[up_q];
      t_q    <= qfirst_q[qi];
      qf_q   <= qfirst_q[qi];
      ql_q   <= qlast_q[qi];
      tlk_q  <= wlk_q[qfirst_q[qi]];
      ts_q   <= qfirst_q[qi];
    end
  end

  logic [2:0] st;
  logic [StackBits-1:0] so;
  logic [SlotBits-1:0] sn;
  always_comb begin
    st = ST_OK; so = '0; sn = '0;
    case (r_q.op)
      OP_PUSH: begin
        if (r_q.stack_value == '0) st = ST_NULL;
        else if (used_q == 5'(MaxThreads)) st = ST_FULL;
      end
      OP_ADVANCE: begin
        if (used_q == '0) st = ST_EMPTY;
        else begin sn = up_q; so = ustk_q; end
      end
      OP_SAVE: if (!runv_q) st = ST_EMPTY;
      OP_READ: begin
        if (!runv_q) st = ST_EMPTY;
        else begin sn = run_q; so = cstk_q; end
      end
      OP_BLOCK: begin
        if (!runv_q) st = ST_EMPTY;
        else if (head_q == tail_q) st = ST_ORPHAN;
      end
      OP_RESUME: begin
        if (!qocc_q[qi]) st = ST_QEMPTY;
        else if (!runv_q) st = ST_EMPTY;
        else sn = t_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.status      <= st;
      rsp_q.thread_slot <= sn;
      rsp_q.stack_out   <= (r_q.op == OP_RESUME && st == ST_OK) ? stk_q[ts_q] : so;
      case (r_q.op)
        OP_PUSH: if (st == ST_OK) begin
          stk_q[us] <= r_q.stack_value;
          if (used_q == '0) begin
            fwd_q[us] <= us; bwd_q[us] <= us;
          end else begin
            fwd_q[us] <= tfwd_q; bwd_q[us] <= tail_q;
            fwd_q[tail_q] <= us; bwd_q[head_q] <= us;
          end
        end
        OP_SAVE: if (st == ST_OK) stk_q[run_q] <= r_q.stack_value;
        OP_BLOCK: if (runv_q) begin
          if (qocc_q[qi]) wlk_q[ql_q] <= run_q;
          else qfirst_q[qi] <= run_q;
          qlast_q[qi] <= run_q;
          bwd_q[cfwd_q] <= cbwd_q;
          fwd_q[cbwd_q] <= cfwd_q;
        end
        OP_RESUME: if (st == ST_OK) begin
          fwd_q[t_q] <= cfwd_q;
          bwd_q[t_q] <= run_q;
          bwd_q[up_q] <= t_q;
          fwd_q[run_q] <= t_q;
          if (qf_q != ql_q) qfirst_q[qi] <= tlk_q;
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qocc_q <= '0; used_q <= '0; run_q <= '0; runv_q <= 1'b0;
      up_q <= '0; head_q <= '0; tail_q <= '0; strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        case (r_q.op)
          OP_PUSH: if (st == ST_OK) begin
            if (used_q == '0) begin
              head_q <= us; tail_q <= us; up_q <= us;
            end else tail_q <= us;
            used_q <= used_q + 1'b1;
          end
          // upcoming's forward link is read as of now (sn == up_q)
          OP_ADVANCE: if (st == ST_OK) begin
            run_q <= up_q; runv_q <= 1'b1; up_q <= fwd_q[up_q];
          end
          OP_BLOCK: if (runv_q) begin
            qocc_q[qi] <= 1'b1;
            if (head_q == run_q) head_q <= cfwd_q;
            if (tail_q == run_q) tail_q <= cbwd_q;
          end
          OP_RESUME: if (st == ST_OK) begin
            up_q <= t_q;
            if (run_q == tail_q) tail_q <= t_q;
            if (qf_q == ql_q) qocc_q[qi] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;
endmodule
